@@ hw/rtl/sidcrc_pkg.sv @@
// Package for the sync/ID framed byte parser with CRC-16/MODBUS check.
// Holds the payload structs, frame constants and status codes.
// No dependencies; the parser top and the CRC unit import this package.
`default_nettype none

package sidcrc_pkg;

  localparam int DEFAULT_FRAME_CAPACITY = 64;

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
  localparam logic [1:0] STATUS_OVERSIZE  = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ID_HIGH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ID_LOW  = 2'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic [1:0] frame_status;
  } out_item_t;

  // Command from the parser to the bit-serial CRC unit
  typedef struct packed {
    logic       start;
    logic       init;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/sidcrc_stream_if.sv @@
// Valid/ready stream interface with a payload of a given type.
// No dependencies; the payload type is set where the interface is instantiated.
`default_nettype none

interface sidcrc_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/sync_id_crc16_frame_parser.sv @@
// Top level of the sync/ID framed byte parser with CRC-16/MODBUS check.
// Depends on sidcrc_pkg, sidcrc_stream_if and sidcrc_crc.
//
//   port        | dir | payload                                     | transfer
//   ------------+-----+---------------------------------------------+-------------
//   byte_in     | in  | rx_byte[7:0]                                | valid & ready
//   result_out  | out | frame_byte[7:0], last_of_frame, status[1:0] | valid & ready
//   cfg_*       | in  | cfg_index[1:0], cfg_data[7:0]               | cfg_we
//
// A byte that is held and covered by the CRC stalls the input until the bit-serial
// CRC unit, which folds one bit per cycle, has folded it in. Other bytes do not stall.
// A good frame drains from the frame store one result at a time (registered
// memory read, then output register), no input taken meanwhile.
// Reset (rst, synchronous) returns to hunting the first sync byte; no clearing pass.
// Output stalls hold the output register; the length byte and the CRC low byte wait
// for it to free up, while other bytes still transfer.
`default_nettype none

module sync_id_crc16_frame_parser #(
  parameter int FRAME_CAPACITY = sidcrc_pkg::DEFAULT_FRAME_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  sidcrc_stream_if.sink                      byte_in,
  sidcrc_stream_if.source                    result_out,
  input  logic                               cfg_we,
  input  logic [sidcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sidcrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sidcrc_pkg::*;

  localparam int IDX_W = $clog2(FRAME_CAPACITY);
  localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
  localparam int LEN_W = 9;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(FRAME_CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(FRAME_CAPACITY);

  typedef enum logic [2:0] {
    P_HUNT1, P_HUNT2, P_LEN, P_IDH, P_IDL, P_DATA, P_CRCH, P_CRCL
  } parse_t;

  typedef enum logic [1:0] {E_IDLE, E_CRC, E_READ, E_EMIT} eng_t;

  parse_t           parse_step;
  eng_t             eng;
  logic [7:0]       device_id_high;
  logic [7:0]       device_id_low;
  logic [7:0]       frame_length;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       crc_received_high;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;
  logic             out_valid;
  out_item_t        out_item;

  logic [7:0]       frame_store [FRAME_CAPACITY];

  logic [7:0]       rx;
  logic             out_free;
  logic             out_load;
  logic             gives_result;
  logic             accept;
  logic [LEN_W-1:0] rx_len_p1;
  logic [LEN_W-1:0] len_p1;
  logic             oversize;
  logic             hold;
  logic [CNT_W-1:0] count_base;
  logic [CNT_W-1:0] count_inc;
  logic [LEN_W-1:0] fold_limit;
  logic             fold;
  logic             crc_match;
  logic             drain_last;
  crc_cmd_t         crc_cmd;
  logic [15:0]      crc_value;
  logic             crc_busy;

  assign rx           = byte_in.data.rx_byte;
  assign out_free     = !out_valid || result_out.ready;
  assign gives_result = (parse_step == P_LEN) || (parse_step == P_CRCL);
  assign byte_in.ready = (eng == E_IDLE) && (!gives_result || out_free);
  assign accept       = byte_in.valid && byte_in.ready;

  assign rx_len_p1  = {1'b0, rx} + LEN_W'(1);
  assign len_p1     = {1'b0, frame_length} + LEN_W'(1);
  assign oversize   = rx_len_p1 > CAP_LEN;

  always_comb begin
    hold = 1'b0;
    unique case (parse_step)
      P_LEN:   hold = !oversize;
      P_IDH:   hold = (rx == device_id_high);
      P_IDL:   hold = (rx == device_id_low);
      P_DATA:  hold = 1'b1;
      default: hold = 1'b0;
    endcase
    hold = hold && accept;
  end

  // the length byte restarts the count and the CRC
  assign count_base = (parse_step == P_LEN) ? '0 : byte_count;
  assign count_inc  = count_base + CNT_W'(1);
  assign fold_limit = (parse_step == P_LEN) ? rx_len_p1 : len_p1;
  assign fold       = hold && (LEN_W'(count_base) < fold_limit);

  assign crc_cmd.start = fold;
  assign crc_cmd.init  = (parse_step == P_LEN);
  assign crc_cmd.data  = rx;

  assign crc_match  = ({crc_received_high, rx} == crc_value);
  assign drain_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == byte_count);

  // a new result enters the output register this cycle
  assign out_load = ((eng == E_EMIT) && out_free) ||
                    (accept && (((parse_step == P_LEN) && oversize) ||
                                ((parse_step == P_CRCL) && !crc_match)));

  sidcrc_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .crc  (crc_value),
    .busy (crc_busy)
  );

  always_ff @(posedge clk) begin
    if (hold) begin
      frame_store[count_base[IDX_W-1:0]] <= rx;
    end
    rd_data <= frame_store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_step        <= P_HUNT1;
      eng               <= E_IDLE;
      out_valid         <= 1'b0;
      device_id_high    <= '0;
      device_id_low     <= '0;
      frame_length      <= '0;
      byte_count        <= '0;
      crc_received_high <= '0;
      rd_idx            <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEVICE_ID_HIGH) begin
          device_id_high <= cfg_data;
        end else if (cfg_index == CFG_DEVICE_ID_LOW) begin
          device_id_low <= cfg_data;
        end
      end

      if (out_valid && result_out.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (eng)
        E_IDLE: begin
          if (accept) begin
            if (hold) begin
              byte_count <= count_inc;
            end
            if (fold) begin
              eng <= E_CRC;
            end
            unique case (parse_step)
              P_HUNT1: begin
                if (rx == SYNC_FIRST) begin
                  parse_step <= P_HUNT2;
                end
              end
              P_HUNT2: parse_step <= (rx == SYNC_SECOND) ? P_LEN : P_HUNT1;
              P_LEN: begin
                frame_length <= rx;
                if (oversize) begin
                  out_valid  <= 1'b1;
                  out_item   <= '{frame_byte: 8'h00, last_of_frame: 1'b1,
                                  frame_status: STATUS_OVERSIZE};
                  parse_step <= P_HUNT1;
                end else begin
                  parse_step <= P_IDH;
                end
              end
              P_IDH: parse_step <= (rx == device_id_high) ? P_IDL : P_HUNT1;
              P_IDL: parse_step <= (rx == device_id_low) ? P_DATA : P_HUNT1;
              P_DATA: begin
                if ((LEN_W'(count_inc) >= len_p1) || (count_inc == CAP_CNT)) begin
                  parse_step <= P_CRCH;
                end
              end
              P_CRCH: begin
                crc_received_high <= rx;
                parse_step        <= P_CRCL;
              end
              P_CRCL: begin
                parse_step <= P_HUNT1;
                if (crc_match) begin
                  rd_idx <= '0;
                  eng    <= E_READ;
                end else begin
                  out_valid <= 1'b1;
                  out_item  <= '{frame_byte: 8'h00, last_of_frame: 1'b1,
                                 frame_status: STATUS_CRC_ERROR};
                end
              end
            endcase
          end
        end
        E_CRC: begin
          if (!crc_busy) begin
            eng <= E_IDLE;
          end
        end
        E_READ: eng <= E_EMIT;
        E_EMIT: begin
          // hold the read byte until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            out_item  <= '{frame_byte: rd_data, last_of_frame: drain_last,
                           frame_status: STATUS_OK};
            if (drain_last) begin
              eng <= E_IDLE;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
              eng    <= E_READ;
            end
          end
        end
      endcase
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.data  = out_item;

  a_crc_busy_in_crc_state: assert property (@(posedge clk) disable iff (rst)
    crc_busy |-> eng == E_CRC)
    else $error("CRC unit busy outside the CRC wait state");

  a_error_is_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_status != STATUS_OK)
      |-> (out_item.last_of_frame && out_item.frame_byte == 8'h00))
    else $error("error result not a single zero result");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CAP_CNT)
    else $error("byte count beyond frame capacity");

  a_drain_while_hunting: assert property (@(posedge clk) disable iff (rst)
    (eng == E_READ || eng == E_EMIT) |-> parse_step == P_HUNT1)
    else $error("frame drain while the parser is not hunting");

  a_good_crc_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (accept && parse_step == P_CRCL && crc_match) |=> eng == E_READ)
    else $error("matching CRC did not start the frame drain");

endmodule

`default_nettype wire

@@ hw/rtl/sidcrc_crc.sv @@
// Bit-serial CRC-16/MODBUS unit: folds one byte bit by bit, busy while it does.
// Depends on sidcrc_pkg for the command struct and CRC constants.
`default_nettype none

module sidcrc_crc (
  input  logic                 clk,
  input  logic                 rst,
  input  sidcrc_pkg::crc_cmd_t cmd,
  output logic [15:0]          crc,
  output logic                 busy
);
  import sidcrc_pkg::*;

  localparam logic [2:0] LAST_BIT = 3'd7;

  logic [7:0] shift;
  logic [2:0] bit_cnt;
  logic       feedback;

  assign feedback = crc[0] ^ shift[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= CRC_INIT;
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (cmd.start) begin
      crc     <= cmd.init ? CRC_INIT : crc;
      shift   <= cmd.data;
      bit_cnt <= '0;
      busy    <= 1'b1;
    end else if (busy) begin
      // one data bit per cycle, lsb first
      crc     <= {1'b0, crc[15:1]} ^ (feedback ? CRC_POLY : 16'h0000);
      shift   <= {1'b0, shift[7:1]};
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == LAST_BIT) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
